// ===== rtl/zrmt_pkg.sv =====
`timescale 1ns / 1ps
package zrmt_pkg;

    localparam int RUN_COUNT_BITS = 16;
    localparam int LEN_W          = RUN_COUNT_BITS + 1;
    localparam int POS_W          = $clog2(RUN_COUNT_BITS + 1);

    localparam logic [6:0] SYM_ONE    = 7'd2;
    localparam logic [6:0] CLASS_BASE = 7'd3;
    localparam logic [2:0] MODEL_RUN  = 3'd0;

    localparam logic [7:0] CLASS_OFFSET [7] = '{8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128};

    typedef struct packed {
        logic [7:0] byte_value;
        logic       block_end;
    } t_in_word;

    typedef struct packed {
        logic [2:0] model_index;
        logic [6:0] token_symbol;
        logic       last_of_run;
        logic       run_overflow;
    } t_out_word;

    typedef struct packed {
        logic             load;
        logic             shift;
        logic [LEN_W-1:0] load_len;
    } t_shift_cmd;

    typedef struct packed {
        logic lead;
        logic bit_below;
        logic pos_one;
    } t_shift_stat;

endpackage

// ===== rtl/zero_run_magnitude_tokenizer_core.sv =====
`timescale 1ns / 1ps
// channel | valid   | stall   | word
// input   | i_valid | o_stall | i_in_word  (byte_value, block_end)
// output  | o_valid | i_stall | o_out_word (model_index, token_symbol, last_of_run, run_overflow)
//
// A zero byte that is not final only extends the run count and gives no word.
// A run flush normalizes n+1 in the shift unit, then sends one run token per cycle
// while the output is not stalled.
// A byte of one adds a class token, any other non-zero byte a class and a remainder token.
// Output word is registered; the next input word is taken while it waits.
// Synchronous active-low reset clears the run counter, overflow flag, output valid and sequencer.
module zero_run_magnitude_tokenizer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  zrmt_pkg::t_in_word i_in_word,
    output logic               o_valid,
    input  logic               i_stall,
    output zrmt_pkg::t_out_word o_out_word
);
    import zrmt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_CLS  = 3'd3;
    localparam logic [2:0] S_REM  = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [RUN_COUNT_BITS-1:0] r_run_count, n_run_count;
    logic                      r_ovf, n_ovf;
    logic                      r_flush_ovf, n_flush_ovf;
    logic [7:0]                r_byte, n_byte;
    logic                      r_has_byte, n_has_byte;
    logic                      r_o_valid, n_o_valid;
    t_out_word                 r_out, n_out;

    t_shift_cmd                shift_cmd;
    t_shift_stat               shift_stat;
    logic [2:0]                byte_model;
    logic [6:0]                byte_sym;
    logic [6:0]                byte_rem;

    logic                      in_take;
    logic                      out_free;
    logic                      is_zero;
    logic [RUN_COUNT_BITS-1:0] cnt_zero;
    logic                      ovf_zero;
    logic [RUN_COUNT_BITS-1:0] cnt_flush;
    logic                      ovf_flush;

    zrmt_shift_unit u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (shift_cmd),
        .o_stat  (shift_stat)
    );

    zrmt_byte_class u_class (
        .i_byte      (r_byte),
        .o_model     (byte_model),
        .o_class_sym (byte_sym),
        .o_remainder (byte_rem)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign is_zero  = (i_in_word.byte_value == 8'd0);

    assign cnt_zero  = (&r_run_count) ? r_run_count : r_run_count + RUN_COUNT_BITS'(1);
    assign ovf_zero  = r_ovf || (&r_run_count);
    assign cnt_flush = is_zero ? cnt_zero : r_run_count;
    assign ovf_flush = is_zero ? ovf_zero : r_ovf;

    always_comb begin
        n_state     = r_state;
        n_run_count = r_run_count;
        n_ovf       = r_ovf;
        n_flush_ovf = r_flush_ovf;
        n_byte      = r_byte;
        n_has_byte  = r_has_byte;
        n_o_valid   = r_o_valid;
        n_out       = r_out;
        shift_cmd   = '0;
        shift_cmd.load_len = {1'b0, cnt_flush} + {{RUN_COUNT_BITS{1'b0}}, 1'b1};

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_byte     = i_in_word.byte_value;
                    n_has_byte = !is_zero;
                    if ((is_zero && i_in_word.block_end) ||
                        (!is_zero && (r_run_count != '0))) begin
                        shift_cmd.load = 1'b1;
                        n_flush_ovf    = ovf_flush;
                        n_run_count    = '0;
                        n_ovf          = 1'b0;
                        n_state        = S_NORM;
                    end else if (is_zero) begin
                        n_run_count = cnt_zero;
                        n_ovf       = ovf_zero;
                    end else begin
                        n_state = S_CLS;
                    end
                end
            end
            S_NORM: begin
                if (shift_stat.lead) begin
                    n_state = S_RUN;
                end else begin
                    shift_cmd.shift = 1'b1;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    shift_cmd.shift         = 1'b1;
                    n_o_valid               = 1'b1;
                    n_out.model_index       = MODEL_RUN;
                    n_out.token_symbol      = {6'd0, shift_stat.bit_below};
                    n_out.last_of_run       = shift_stat.pos_one && !r_has_byte;
                    n_out.run_overflow      = r_flush_ovf;
                    if (shift_stat.pos_one) begin
                        n_state = r_has_byte ? S_CLS : S_IDLE;
                    end
                end
            end
            S_CLS: begin
                if (out_free) begin
                    n_o_valid          = 1'b1;
                    n_out.model_index  = MODEL_RUN;
                    n_out.token_symbol = byte_sym;
                    n_out.last_of_run  = (byte_sym == SYM_ONE);
                    n_out.run_overflow = 1'b0;
                    n_state            = (byte_sym == SYM_ONE) ? S_IDLE : S_REM;
                end
            end
            S_REM: begin
                if (out_free) begin
                    n_o_valid          = 1'b1;
                    n_out.model_index  = byte_model;
                    n_out.token_symbol = byte_rem;
                    n_out.last_of_run  = 1'b1;
                    n_out.run_overflow = 1'b0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_count <= '0;
            r_ovf       <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_count <= n_run_count;
            r_ovf       <= n_ovf;
            r_o_valid   <= n_o_valid;
        end
        r_flush_ovf <= n_flush_ovf;
        r_byte      <= n_byte;
        r_has_byte  <= n_has_byte;
        r_out       <= n_out;
    end

    assign o_valid    = r_o_valid;
    assign o_out_word = r_out;

    a_nonzero_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !is_zero) |=> o_stall)
        else $error("non-zero byte did not start a token sequence");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_out_word.last_of_run) |=> o_valid)
        else $error("token sequence broken before its last word");

    a_ovf_model: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_word.run_overflow) |-> (o_out_word.model_index == MODEL_RUN))
        else $error("overflow flag on a non-run token");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_NORM) || (r_state == S_RUN)) |-> (r_run_count == '0))
        else $error("run counter not cleared during flush");

endmodule

// ===== rtl/zrmt_shift_unit.sv =====
`timescale 1ns / 1ps
module zrmt_shift_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  zrmt_pkg::t_shift_cmd i_cmd,
    output zrmt_pkg::t_shift_stat o_stat
);
    import zrmt_pkg::*;

    logic [LEN_W-1:0] r_len, n_len;
    logic [POS_W-1:0] r_pos, n_pos;

    always_comb begin
        n_len = r_len;
        n_pos = r_pos;
        if (i_cmd.load) begin
            n_len = i_cmd.load_len;
            n_pos = POS_W'(RUN_COUNT_BITS);
        end else if (i_cmd.shift) begin
            n_len = {r_len[LEN_W-2:0], 1'b0};
            n_pos = r_pos - POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
        r_len <= n_len;
    end

    assign o_stat.lead      = r_len[LEN_W-1];
    assign o_stat.bit_below = r_len[LEN_W-2];
    assign o_stat.pos_one   = (r_pos == POS_W'(1));

endmodule

// ===== rtl/zrmt_byte_class.sv =====
`timescale 1ns / 1ps
module zrmt_byte_class (
    input  logic [7:0] i_byte,
    output logic [2:0] o_model,
    output logic [6:0] o_class_sym,
    output logic [6:0] o_remainder
);
    import zrmt_pkg::*;

    logic [2:0] lead;
    logic [2:0] cls;
    logic [7:0] diff;

    always_comb begin
        lead = 3'd0;
        for (int b = 1; b < 8; b++) begin
            if (i_byte[b]) begin
                lead = 3'(b);
            end
        end
    end

    // class index = leading one position minus one; clamped for bytes 0 and 1
    assign cls         = (lead == 3'd0) ? 3'd0 : lead - 3'd1;
    assign diff        = i_byte - CLASS_OFFSET[cls];
    assign o_model     = lead;
    assign o_class_sym = (i_byte[7:1] == 7'd0) ? SYM_ONE : CLASS_BASE + {4'd0, cls};
    assign o_remainder = diff[6:0];

endmodule
